// ----- src/ctst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctst_pkg: shared types and constants
// Leg width, derived widths and the front-to-back job record.
// ----------------------------------------------------------------------------
package ctst_pkg;
    localparam int LEG_BITS = 21;
    localparam int SQ_BITS  = 2 * LEG_BITS;
    localparam int R_BITS   = 128;
    localparam int ROOT_BITS = 64;
    // Operand widths of the multi-cycle product: A is up to three 32-bit
    // chunks, B up to two.
    localparam int MUL_BITS = 32;
    localparam int MA_BITS  = 3 * MUL_BITS;
    localparam int MB_BITS  = 2 * MUL_BITS;
    localparam int GK_BITS  = 5;

    typedef struct packed {
        logic [LEG_BITS-1:0] x;
        logic [LEG_BITS-1:0] y;
        logic [LEG_BITS-1:0] z;
        logic                order_error;
        logic                on_family_a;
    } t_job;
endpackage

// ----- src/cuboid_triple_square_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuboid_triple_square_test: square test of a cuboid triple product
// Forms R = (x^2+y^2)(x^2-z^2)(y^2-z^2) and reports its integer root,
// squareness, common factor, family A and ordering flags.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// input     i_push / o_full  i_side_x, i_side_y, i_side_z
// result    o_empty / i_pop  o_hit .. o_root
//
// The back engine runs fixed steps per request (three squares, the product
// x*y*z, twelve 32x32 partial products, 64 root steps, a final check and a
// closing step for each gcd pass) plus the steps of two binary gcd passes,
// whose number depends on the legs. A misordered triple skips R and the root.
// The front classifies the next request while the back works; a two-entry
// queue sits between them. Reset is synchronous and clears all control
// state. A result waits on the ports until popped, and the back stalls then.
// ----------------------------------------------------------------------------
module cuboid_triple_square_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [ctst_pkg::LEG_BITS-1:0] i_side_x,
    input  logic [ctst_pkg::LEG_BITS-1:0] i_side_y,
    input  logic [ctst_pkg::LEG_BITS-1:0] i_side_z,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_hit,
    output logic        o_is_square,
    output logic        o_has_common_factor,
    output logic        o_on_family_a,
    output logic        o_order_error,
    output logic        o_q_positive,
    output logic [ctst_pkg::ROOT_BITS-1:0] o_root
);
    import ctst_pkg::*;

    logic w_fv, w_fr, w_qv, w_take;
    t_job w_fjob, w_qjob;

    // Front end: takes the request and classifies ordering and family A.
    ctst_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_side_x, .i_side_y, .i_side_z,
        .o_valid(w_fv), .i_ready(w_fr), .o_job(w_fjob)
    );

    ctst_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(w_fv), .o_wr_ready(w_fr), .i_job(w_fjob),
        .o_rd_valid(w_qv), .i_rd(w_take), .o_job(w_qjob)
    );

    // Back end: the arithmetic that decides the request.
    ctst_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_take(w_take), .i_job(w_qjob),
        .o_empty, .i_pop, .o_hit, .o_is_square, .o_has_common_factor,
        .o_on_family_a, .o_order_error, .o_q_positive, .o_root
    );

`ifndef ASSERT_OFF
    a_hit_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_hit |-> o_is_square && !o_order_error)
        else $error("hit without square");
    a_order_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_order_error |-> o_root == '0 && !o_q_positive)
        else $error("misordered triple has root");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_root))
        else $error("result dropped");
`endif
endmodule

// ----- src/ctst_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctst_front: intake and classification
// Registers a triple, forms y*y and x*z, then checks ordering and the
// family A relation and hands the job to the queue.
// ----------------------------------------------------------------------------
module ctst_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [ctst_pkg::LEG_BITS-1:0] i_side_x,
    input  logic [ctst_pkg::LEG_BITS-1:0] i_side_y,
    input  logic [ctst_pkg::LEG_BITS-1:0] i_side_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output ctst_pkg::t_job           o_job
);
    import ctst_pkg::*;

    logic                r_busy, r_stage, r_valid;
    logic [LEG_BITS-1:0] r_x, r_y, r_z;
    logic [SQ_BITS-1:0]  r_yy, r_xz;
    t_job                r_job;

    assign o_full  = r_busy;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_stage <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_push && !r_busy) begin
                r_x <= i_side_x;
                r_y <= i_side_y;
                r_z <= i_side_z;
                r_busy  <= 1'b1;
                r_stage <= 1'b0;
            end else if (r_busy && !r_valid && !r_stage) begin
                r_yy    <= r_y * r_y;
                r_xz    <= r_x * r_z;
                r_stage <= 1'b1;
            end else if (r_busy && !r_valid && r_stage) begin
                r_job.x <= r_x;
                r_job.y <= r_y;
                r_job.z <= r_z;
                r_job.order_error <= !((r_z != '0) && (r_z < r_y) && (r_y < r_x));
                r_job.on_family_a <= (r_yy == r_xz);
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
                r_busy  <= 1'b0;
            end
        end
    end
endmodule

// ----- src/ctst_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctst_queue: two-entry job queue
// Decouples the front from the back so either may stall.
// ----------------------------------------------------------------------------
module ctst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    output logic           o_wr_ready,
    input  ctst_pkg::t_job i_job,
    output logic           o_rd_valid,
    input  logic           i_rd,
    output ctst_pkg::t_job o_job
);
    import ctst_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_job      = r_mem[r_rp];
    assign w_wr = i_wr && o_wr_ready;
    assign w_rd = i_rd && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule

// ----- src/ctst_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctst_back: arithmetic engine
// Sequencer over a shared 32x32 multiplier: builds R, runs a binary gcd,
// takes the square root one bit per step and holds the result.
// ----------------------------------------------------------------------------
module ctst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_take,
    input  ctst_pkg::t_job i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_hit,
    output logic           o_is_square,
    output logic           o_has_common_factor,
    output logic           o_on_family_a,
    output logic           o_order_error,
    output logic           o_q_positive,
    output logic [ctst_pkg::ROOT_BITS-1:0] o_root
);
    import ctst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_PROD, S_GCD1, S_GCD2, S_MUL, S_ROOT, S_CHK, S_DONE
    } t_state;

    t_state               r_state;
    t_job                 r_job;
    logic [SQ_BITS-1:0]   r_xx, r_yy, r_zz;
    logic [MA_BITS-1:0]   r_ma;
    logic [MB_BITS-1:0]   r_mb;
    logic [R_BITS-1:0]    r_acc, r_rem;
    logic [63:0]          r_xyz;
    logic [LEG_BITS-1:0]  r_ga, r_gb;
    logic [GK_BITS-1:0]   r_gk;
    logic [2:0]           r_cnt;
    logic                 r_pass;
    logic [5:0]           r_bit;
    logic [ROOT_BITS-1:0] r_root;
    logic                 r_has_common, r_sq, r_qp;

    logic [MUL_BITS-1:0]  w_ma, w_mb;
    logic [63:0]          w_prod;
    logic [R_BITS-1:0]    w_term, w_trial;
    logic [LEG_BITS-1:0]  w_gcd;

    // shared multiplier: 32x32 per cycle
    assign w_prod = w_ma * w_mb;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQ: begin
                unique case (r_cnt)
                    3'd0:    w_ma = MUL_BITS'(r_job.x);
                    3'd1:    w_ma = MUL_BITS'(r_job.y);
                    default: w_ma = MUL_BITS'(r_job.z);
                endcase
                w_mb = w_ma;
            end
            S_PROD: begin
                unique case (r_cnt)
                    3'd0: begin
                        w_ma = MUL_BITS'(r_job.x);
                        w_mb = MUL_BITS'(r_job.y);
                    end
                    3'd1: begin
                        w_ma = r_ma[31:0];
                        w_mb = MUL_BITS'(r_job.z);
                    end
                    default: begin
                        w_ma = r_ma[63:32];
                        w_mb = MUL_BITS'(r_job.z);
                    end
                endcase
            end
            S_MUL: begin
                // r_cnt[2:1] picks the chunk of A, r_cnt[0] the chunk of B.
                unique case (r_cnt[2:1])
                    2'd0:    w_ma = r_ma[31:0];
                    2'd1:    w_ma = r_ma[63:32];
                    default: w_ma = r_ma[95:64];
                endcase
                w_mb = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
            end
            default: ;
        endcase
    end

    // Partial product placed at 32 times the sum of the chunk indexes.
    assign w_term = R_BITS'(w_prod)
                  << {({1'b0, r_cnt[2:1]} + {2'b00, r_cnt[0]}), 5'd0};

    // restoring root on remainder: trial = (root << (bit+1)) + 4^bit
    assign w_trial = ({64'd0, r_root} << ({1'b0, r_bit} + 7'd1))
                   | (R_BITS'(1) << {r_bit, 1'b0});

    assign w_gcd = r_ga << r_gk;

    assign o_take  = (r_state == S_IDLE) && i_valid;
    assign o_empty = (r_state != S_DONE);
    assign o_root  = r_root;
    assign o_is_square = r_sq;
    assign o_q_positive = r_qp;
    assign o_has_common_factor = r_has_common;
    assign o_on_family_a = r_job.on_family_a;
    assign o_order_error = r_job.order_error;
    assign o_hit = r_sq && !r_has_common && !r_job.on_family_a && !r_job.order_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job   <= i_job;
                        r_cnt   <= '0;
                        r_sq    <= 1'b0;
                        r_qp    <= 1'b0;
                        r_root  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    unique case (r_cnt)
                        3'd0:    r_xx <= SQ_BITS'(w_prod);
                        3'd1:    r_yy <= SQ_BITS'(w_prod);
                        default: r_zz <= SQ_BITS'(w_prod);
                    endcase
                    if (r_cnt == 3'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_PROD;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_PROD: begin
                    // xy first, then xy*z from its low and high words
                    unique case (r_cnt)
                        3'd0:    r_ma  <= MA_BITS'(w_prod);
                        3'd1:    r_xyz <= w_prod;
                        default: r_xyz <= r_xyz + {w_prod[31:0], 32'd0};
                    endcase
                    if (r_cnt == 3'd2) begin
                        r_cnt   <= '0;
                        r_ga    <= r_job.x;
                        r_gb    <= r_job.y;
                        r_gk    <= '0;
                        r_state <= S_GCD1;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_GCD1, S_GCD2: begin
                    // binary gcd, one step per cycle; r_gk counts shared twos
                    if (r_gb == '0) begin
                        if (r_state == S_GCD1) begin
                            r_ga    <= w_gcd;
                            r_gb    <= r_job.z;
                            r_gk    <= '0;
                            r_state <= S_GCD2;
                        end else begin
                            r_has_common <= (w_gcd > LEG_BITS'(1));
                            r_ma   <= MA_BITS'(r_xx - r_zz);
                            r_mb   <= MB_BITS'(r_yy - r_zz);
                            r_acc  <= '0;
                            r_pass <= 1'b0;
                            r_cnt  <= '0;
                            r_state <= r_job.order_error ? S_DONE : S_MUL;
                        end
                    end else if (r_ga == '0) begin
                        r_ga <= r_gb;
                        r_gb <= '0;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_gk <= r_gk + GK_BITS'(1);
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= r_gb;
                        r_gb <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                S_MUL: begin
                    // first pass: (xx-zz)*(yy-zz); second pass: that times xx+yy
                    if (r_cnt == 3'd5) begin
                        r_cnt <= '0;
                        if (!r_pass) begin
                            r_pass <= 1'b1;
                            r_ma   <= MA_BITS'(r_acc + w_term);
                            r_mb   <= MB_BITS'(r_xx) + MB_BITS'(r_yy);
                            r_acc  <= '0;
                        end else begin
                            r_rem   <= r_acc + w_term;
                            r_bit   <= '1;
                            r_state <= S_ROOT;
                        end
                    end else begin
                        r_acc <= r_acc + w_term;
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_ROOT: begin
                    if (w_trial <= r_rem) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= r_root | (ROOT_BITS'(1) << r_bit);
                    end
                    if (r_bit == '0) begin
                        r_state <= S_CHK;
                    end else begin
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_CHK: begin
                    r_sq <= (r_rem == '0);
                    r_qp <= r_xyz > r_root;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_pop) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- verif/ctst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctst_checker: result predictor and scoreboard
// Watches both handshake channels of the square test block, predicts each
// result from the accepted triple and compares the results in order.
// ----------------------------------------------------------------------------
module ctst_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [ctst_pkg::LEG_BITS-1:0]  i_side_x,
    input  logic [ctst_pkg::LEG_BITS-1:0]  i_side_y,
    input  logic [ctst_pkg::LEG_BITS-1:0]  i_side_z,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic                           i_hit,
    input  logic                           i_is_square,
    input  logic                           i_has_common_factor,
    input  logic                           i_on_family_a,
    input  logic                           i_order_error,
    input  logic                           i_q_positive,
    input  logic [ctst_pkg::ROOT_BITS-1:0] i_root,
    output int                             o_pending,
    output int                             o_fails
);
    import ctst_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic                 is_square;
        logic                 has_common_factor;
        logic                 on_family_a;
        logic                 order_error;
        logic                 q_positive;
        logic [ROOT_BITS-1:0] root;
    } t_verdict;

    t_verdict expected_verdicts[$];

    function automatic logic [63:0] leg_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Bit-serial floor square root of a 128-bit value.
    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= n) r = cand;
        end
        return r;
    endfunction

    function automatic t_verdict judge_triple(logic [LEG_BITS-1:0] x, logic [LEG_BITS-1:0] y,
                                              logic [LEG_BITS-1:0] z);
        t_verdict v;
        logic [63:0] xx, yy, zz, xz;
        logic [127:0] prod;
        xx = 64'(x) * 64'(x);
        yy = 64'(y) * 64'(y);
        zz = 64'(z) * 64'(z);
        xz = 64'(x) * 64'(z);
        v = '0;
        v.order_error = !(z >= 1 && z < y && y < x);
        v.has_common_factor = leg_gcd(leg_gcd(64'(x), 64'(y)), 64'(z)) > 1;
        v.on_family_a = (yy == xz);
        if (!v.order_error) begin
            prod = 128'(xx - zz) * 128'(yy - zz) * 128'(xx + yy);
            v.root = floor_root(prod);
            v.is_square = ({64'd0, v.root} * {64'd0, v.root} == prod);
            v.q_positive = (64'(x) * 64'(y) * 64'(z)) > v.root;
        end
        v.hit = v.is_square && !v.has_common_factor && !v.on_family_a && !v.order_error;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            o_fails <= 0;
        end else begin
            if (i_push && !i_full)
                expected_verdicts.push_back(judge_triple(i_side_x, i_side_y, i_side_z));
            if (i_pop && !i_empty) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result popped with no request outstanding");
                    o_fails <= o_fails + 1;
                end else begin
                    want = expected_verdicts.pop_front();
                    if ({i_hit, i_is_square, i_has_common_factor, i_on_family_a,
                         i_order_error, i_q_positive, i_root} != want) begin
                        o_fails <= o_fails + 1;
                        if (i_hit != want.hit)
                            $error("hit: expected %0d, got %0d", want.hit, i_hit);
                        if (i_is_square != want.is_square)
                            $error("is_square: expected %0d, got %0d",
                                   want.is_square, i_is_square);
                        if (i_has_common_factor != want.has_common_factor)
                            $error("has_common_factor: expected %0d, got %0d",
                                   want.has_common_factor, i_has_common_factor);
                        if (i_on_family_a != want.on_family_a)
                            $error("on_family_a: expected %0d, got %0d",
                                   want.on_family_a, i_on_family_a);
                        if (i_order_error != want.order_error)
                            $error("order_error: expected %0d, got %0d",
                                   want.order_error, i_order_error);
                        if (i_q_positive != want.q_positive)
                            $error("q_positive: expected %0d, got %0d",
                                   want.q_positive, i_q_positive);
                        if (i_root != want.root)
                            $error("root: expected %0d, got %0d", want.root, i_root);
                    end
                end
            end
        end
        o_pending <= expected_verdicts.size();
    end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level for the cuboid triple square test
// Drives directed and random triples through the block under four idling
// phases and leaves all checking to the scoreboard module beside it.
// ----------------------------------------------------------------------------
module tb;
    import ctst_pkg::*;

    localparam int RANDOM_PER_PHASE = 500;
    localparam logic [LEG_BITS-1:0] LEG_MAX = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_push = 1'b0;
    logic                 i_pop = 1'b0;
    logic [LEG_BITS-1:0]  i_side_x = '0;
    logic [LEG_BITS-1:0]  i_side_y = '0;
    logic [LEG_BITS-1:0]  i_side_z = '0;
    logic                 o_full, o_empty;
    logic                 o_hit, o_is_square, o_has_common_factor;
    logic                 o_on_family_a, o_order_error, o_q_positive;
    logic [ROOT_BITS-1:0] o_root;
    int                   pending, fails;

    // Idling percentages for the current phase, one for each side.
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int phase = 0;
    // Set while the receiver is held off to fill the block up.
    logic hold_results = 1'b0;

    always #2 i_clk = ~i_clk;

    cuboid_triple_square_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_side_x(i_side_x), .i_side_y(i_side_y), .i_side_z(i_side_z),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_hit(o_hit), .o_is_square(o_is_square),
        .o_has_common_factor(o_has_common_factor), .o_on_family_a(o_on_family_a),
        .o_order_error(o_order_error), .o_q_positive(o_q_positive), .o_root(o_root)
    );

    ctst_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .i_full(o_full),
        .i_side_x(i_side_x), .i_side_y(i_side_y), .i_side_z(i_side_z),
        .i_empty(o_empty), .i_pop(i_pop),
        .i_hit(o_hit), .i_is_square(o_is_square),
        .i_has_common_factor(o_has_common_factor), .i_on_family_a(o_on_family_a),
        .i_order_error(o_order_error), .i_q_positive(o_q_positive), .i_root(o_root),
        .o_pending(pending), .o_fails(fails)
    );

    // Offers one request and returns once the block has taken it. An idle
    // gap lowers push first; otherwise push stays high from the previous
    // request, so it is never lowered and raised in the same step.
    task automatic offer_triple(logic [LEG_BITS-1:0] x, logic [LEG_BITS-1:0] y,
                                logic [LEG_BITS-1:0] z);
        logic taken;
        if ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_push   <= 1'b1;
        i_side_x <= x;
        i_side_y <= y;
        i_side_z <= z;
        // The full flag is stable at the falling edge before the sampling edge.
        do begin
            @(negedge i_clk);
            taken = !o_full;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Random well-ordered triple, mostly of modest size so that all widths
    // get exercised; z < y < x holds by construction.
    task automatic offer_ordered();
        int unsigned bits;
        logic [LEG_BITS-1:0] x, y, z;
        bits = $urandom_range(LEG_BITS, 2);
        x = LEG_BITS'($urandom_range((32'd1 << bits) - 1, 3));
        y = LEG_BITS'($urandom_range(x - 1, 2));
        z = LEG_BITS'($urandom_range(y - 1, 1));
        offer_triple(x, y, z);
    endtask

    task automatic offer_random_mix();
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        if (pick < 70) begin
            offer_ordered();
        end else if (pick < 80) begin
            // Family A with a common scale: x = 36k, y = 18k, z = 9k, so y*y = x*z.
            k = $urandom_range(40, 1);
            offer_triple(LEG_BITS'(k * 4 * 9), LEG_BITS'(k * 2 * 3 * 3),
                         LEG_BITS'(k * 9));
        end else if (pick < 88) begin
            k = $urandom_range(9, 2);
            offer_triple(LEG_BITS'(k * $urandom_range(999, 201)),
                         LEG_BITS'(k * $urandom_range(200, 101)),
                         LEG_BITS'(k * $urandom_range(100, 1)));
        end else begin
            // Noise: full-width fields, mostly misordered.
            offer_triple(LEG_BITS'($urandom), LEG_BITS'($urandom), LEG_BITS'($urandom));
        end
    endtask

    // Receiver: pops at random according to the phase, and not at all while
    // the hold-off is in force.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_pop <= 1'b0;
        else
            i_pop <= !hold_results && ($urandom_range(99) >= pop_stall_pct);
    end

    // Long receiver hold-off at the start of the second phase, counted here.
    initial begin
        wait (phase == 1);
        hold_results = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_results = 1'b0;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: extremes, ordering faults, zero legs, common
        // factors and family A triples with square products.
        offer_triple(3, 2, 1);
        offer_triple(LEG_MAX, LEG_BITS'(LEG_MAX - 1), LEG_BITS'(LEG_MAX - 2));
        offer_triple(LEG_MAX, 2, 1);
        offer_triple(LEG_MAX, LEG_BITS'(LEG_MAX - 1), 1);
        offer_triple(0, 0, 0);
        offer_triple(5, 3, 0);
        offer_triple(3, 3, 1);
        offer_triple(3, 2, 2);
        offer_triple(1, 2, 3);
        offer_triple(LEG_MAX, LEG_MAX, LEG_MAX);
        offer_triple(0, LEG_MAX, 7);
        offer_triple(4, 2, 1);
        offer_triple(9, 6, 4);
        offer_triple(8, 4, 2);
        offer_triple(6, 4, 2);
        offer_triple(7, 5, 3);
        offer_triple(LEG_BITS'(LEG_MAX - 1), LEG_BITS'(LEG_MAX - 3), LEG_BITS'(LEG_MAX - 5));
        offer_triple(1048576, 1024, 1);
        offer_triple(1, 1, 1);
        offer_triple(2097150, 1048575, 524288);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 74; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 74; end
                default: begin send_idle_pct = 16; pop_stall_pct = 16; end
            endcase
            phase = p;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                offer_random_mix();
        end
        i_push <= 1'b0;

        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Generous upper bound on the whole run.
    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- cuboid_triple_square_test.f -----
src/ctst_pkg.sv
src/ctst_front.sv
src/ctst_queue.sv
src/ctst_back.sv
src/cuboid_triple_square_test.sv
verif/ctst_checker.sv
verif/tb.sv
